/* hdl/psc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID speed controller package
// Shared widths, reset values, register indexes and the command and status
// types that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int SPEED_WIDTH = 16;
    localparam int GAIN_W      = 16;
    localparam int BOUND_W     = 15;
    localparam int DT_W        = 17;
    localparam int CMD_W       = 16;
    localparam int INT_W       = 16;
    localparam int DERIV_W     = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TIME_FRAC   = 16;
    localparam int ACC_SHIFT   = 8;

    localparam int MUL_A_W = (SPEED_WIDTH > DERIV_W) ? SPEED_WIDTH : DERIV_W;
    localparam int MUL_B_W = DT_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int ISUM_W  = PROD_W - TIME_FRAC + 1;
    localparam int NUM_W   = SPEED_WIDTH + 1 + TIME_FRAC;
    localparam int CNT_W   = $clog2(NUM_W + 1);

    localparam logic [GAIN_W-1:0]  GAIN_P_RST         = 16'd256;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST         = 16'd0;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST         = 16'd13;
    localparam logic [BOUND_W-1:0] INTEGRAL_BOUND_RST = 15'd1280;
    localparam logic [BOUND_W-1:0] ACCEL_BOUND_RST    = 15'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_INTEGRAL_BOUND = 3'd3,
        CFG_ACCEL_BOUND    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [BOUND_W-1:0] integral_bound;
        logic [BOUND_W-1:0] accel_bound;
    } t_cfg;

    typedef enum logic [1:0] {
        MUL_DT,
        MUL_P,
        MUL_I,
        MUL_D
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        logic     load;
        logic     calc_err;
        logic     mul_go;
        t_mul_sel mul_sel;
        logic     div_start;
        logic     integ_upd;
        t_acc_op  acc_op;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_dp_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_DT,
        ST_INTEG,
        ST_MUL_P,
        ST_ACC_P,
        ST_ACC_I,
        ST_DIV_WAIT,
        ST_MUL_D,
        ST_ACC_D,
        ST_FINISH
    } t_state;

endpackage

/* hdl/psc_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID speed controller configuration registers
// Holds the gains and bounds, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module psc_cfg import psc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (t_cfg_idx'(i_index))
                CFG_GAIN_P: begin
                    n_cfg.gain_p = i_wr_data[GAIN_W-1:0];
                end
                CFG_GAIN_I: begin
                    n_cfg.gain_i = i_wr_data[GAIN_W-1:0];
                end
                CFG_GAIN_D: begin
                    n_cfg.gain_d = i_wr_data[GAIN_W-1:0];
                end
                CFG_INTEGRAL_BOUND: begin
                    n_cfg.integral_bound = i_wr_data[BOUND_W-1:0];
                end
                CFG_ACCEL_BOUND: begin
                    n_cfg.accel_bound = i_wr_data[BOUND_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= GAIN_P_RST;
            r_cfg.gain_i         <= GAIN_I_RST;
            r_cfg.gain_d         <= GAIN_D_RST;
            r_cfg.integral_bound <= INTEGRAL_BOUND_RST;
            r_cfg.accel_bound    <= ACCEL_BOUND_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/psc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID speed controller serial divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psc_div import psc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DT_W-1:0]  i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo
);

    logic [DT_W-1:0]  r_rem;
    logic [DT_W-1:0]  n_rem;
    logic [NUM_W-1:0] r_quo;
    logic [NUM_W-1:0] n_quo;
    logic [DT_W-1:0]  r_den;
    logic [DT_W-1:0]  n_den;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    logic [DT_W:0]    w_part;
    logic [DT_W+1:0]  w_trial;
    logic             w_fits;

    assign w_part  = {r_rem, r_quo[NUM_W-1]};
    assign w_trial = {1'b0, w_part} - {2'b00, r_den};
    assign w_fits  = !w_trial[DT_W+1];

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        n_den = r_den;
        n_cnt = r_cnt;
        if (i_start) begin
            n_rem = '0;
            n_quo = i_num;
            n_den = i_den;
            n_cnt = CNT_W'(NUM_W);
        end else if (r_cnt != '0) begin
            n_rem = w_fits ? w_trial[DT_W-1:0] : w_part[DT_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], w_fits};
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule

/* hdl/psc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID speed controller datapath
// Error, integral and derivative state, one shared multiplier, the
// accumulator, the serial divider and the output register.
// ----------------------------------------------------------------------------
module psc_datapath import psc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  t_cfg                   i_cfg,
    input  logic [SPEED_WIDTH-1:0] i_target_speed,
    input  logic [SPEED_WIDTH-1:0] i_measured_speed,
    input  logic [DT_W-1:0]        i_time_step,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic [CMD_W-1:0]       o_accel_command
);

    logic [SPEED_WIDTH-1:0]        r_tgt;
    logic [SPEED_WIDTH-1:0]        r_meas;
    logic [DT_W-1:0]               r_dt;
    logic signed [SPEED_WIDTH-1:0] r_err;
    logic signed [SPEED_WIDTH-1:0] n_err;
    logic                          r_use_d;
    logic                          r_neg;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [ACC_W-1:0]       n_acc;
    logic signed [INT_W-1:0]       r_integ;
    logic signed [INT_W-1:0]       n_integ;
    logic signed [SPEED_WIDTH-1:0] r_prior;
    logic                          r_prior_valid;
    logic                          r_out_valid;
    logic [CMD_W-1:0]              r_cmd;
    logic [CMD_W-1:0]              n_cmd;

    logic signed [SPEED_WIDTH:0]   w_diff;
    logic signed [SPEED_WIDTH:0]   w_ediff;
    logic [SPEED_WIDTH:0]          w_emag;
    logic [NUM_W-1:0]              w_num;
    logic                          w_div_busy;
    logic [NUM_W-1:0]              w_quo;
    logic [NUM_W-1:0]              w_quo_neg;
    logic signed [DERIV_W-1:0]     w_deriv;
    logic signed [MUL_A_W-1:0]     w_mul_a;
    logic signed [MUL_B_W-1:0]     w_mul_b;
    logic signed [PROD_W-1:0]      w_prod;
    logic signed [PROD_W-TIME_FRAC-1:0] w_inc;
    logic signed [ISUM_W-1:0]      w_isum;
    logic signed [ISUM_W-1:0]      w_ib;
    logic signed [ACC_W-ACC_SHIFT-1:0] w_scaled;
    logic signed [ACC_W-ACC_SHIFT-1:0] w_ab;
    logic                          w_out_free;

    assign w_diff = $signed({r_tgt[SPEED_WIDTH-1], r_tgt})
                  - $signed({r_meas[SPEED_WIDTH-1], r_meas});

    always_comb begin
        if (w_diff[SPEED_WIDTH] != w_diff[SPEED_WIDTH-1]) begin
            n_err = w_diff[SPEED_WIDTH] ? $signed({1'b1, {(SPEED_WIDTH-1){1'b0}}})
                                        : $signed({1'b0, {(SPEED_WIDTH-1){1'b1}}});
        end else begin
            n_err = w_diff[SPEED_WIDTH-1:0];
        end
    end

    assign w_ediff = $signed({r_err[SPEED_WIDTH-1], r_err})
                   - $signed({r_prior[SPEED_WIDTH-1], r_prior});
    assign w_emag  = w_ediff[SPEED_WIDTH] ? -w_ediff : w_ediff;
    assign w_num   = {w_emag, {TIME_FRAC{1'b0}}};

    psc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (r_dt),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    assign w_quo_neg = -w_quo;

    always_comb begin
        if (!r_use_d) begin
            w_deriv = '0;
        end else if (r_neg) begin
            if (w_quo > (NUM_W'(1) << (DERIV_W - 1))) begin
                w_deriv = $signed({1'b1, {(DERIV_W-1){1'b0}}});
            end else begin
                w_deriv = w_quo_neg[DERIV_W-1:0];
            end
        end else begin
            if (w_quo > ((NUM_W'(1) << (DERIV_W - 1)) - 1'b1)) begin
                w_deriv = $signed({1'b0, {(DERIV_W-1){1'b1}}});
            end else begin
                w_deriv = w_quo[DERIV_W-1:0];
            end
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_DT: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = $signed({1'b0, r_dt});
            end
            MUL_P: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = MUL_B_W'($signed(i_cfg.gain_p));
            end
            MUL_I: begin
                w_mul_a = MUL_A_W'(r_integ);
                w_mul_b = MUL_B_W'($signed(i_cfg.gain_i));
            end
            MUL_D: begin
                w_mul_a = MUL_A_W'(w_deriv);
                w_mul_b = MUL_B_W'($signed(i_cfg.gain_d));
            end
            default: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = $signed({1'b0, r_dt});
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign w_inc  = $signed(r_prod[PROD_W-1:TIME_FRAC]);
    assign w_isum = ISUM_W'(r_integ) + ISUM_W'(w_inc);
    assign w_ib   = $signed({{(ISUM_W-BOUND_W){1'b0}}, i_cfg.integral_bound});

    always_comb begin
        if (w_isum > w_ib) begin
            n_integ = w_ib[INT_W-1:0];
        end else if (w_isum < -w_ib) begin
            n_integ = INT_W'(-w_ib);
        end else begin
            n_integ = w_isum[INT_W-1:0];
        end
    end

    always_comb begin
        case (i_cmd.acc_op)
            ACC_LOAD: n_acc = ACC_W'(r_prod);
            ACC_ADD:  n_acc = r_acc + ACC_W'(r_prod);
            default:  n_acc = r_acc;
        endcase
    end

    assign w_scaled = $signed(r_acc[ACC_W-1:ACC_SHIFT]);
    assign w_ab     = $signed({{(ACC_W-ACC_SHIFT-BOUND_W){1'b0}}, i_cfg.accel_bound});

    always_comb begin
        if (w_scaled > w_ab) begin
            n_cmd = w_ab[CMD_W-1:0];
        end else if (w_scaled < -w_ab) begin
            n_cmd = CMD_W'(-w_ab);
        end else begin
            n_cmd = w_scaled[CMD_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ       <= '0;
            r_prior       <= '0;
            r_prior_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.integ_upd) begin
                r_integ       <= n_integ;
                r_prior       <= r_err;
                r_prior_valid <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tgt  <= i_target_speed;
            r_meas <= i_measured_speed;
            r_dt   <= i_time_step;
        end
        if (i_cmd.calc_err) begin
            r_err <= n_err;
        end
        if (i_cmd.div_start) begin
            r_use_d <= r_prior_valid && (r_dt != '0);
            r_neg   <= w_ediff[SPEED_WIDTH];
        end
        if (i_cmd.mul_go) begin
            r_prod <= w_prod;
        end
        r_acc <= n_acc;
        if (i_cmd.out_load) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_stat.div_busy = w_div_busy;
    assign o_stat.out_free = w_out_free;
    assign o_out_valid     = r_out_valid;
    assign o_accel_command = r_cmd;

endmodule

/* hdl/psc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID speed controller sequencer
// Steps the datapath through error, integral, products and derivative.
// ----------------------------------------------------------------------------
module psc_ctrl import psc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_ERR;
            ST_ERR:      n_state = ST_MUL_DT;
            ST_MUL_DT:   n_state = ST_INTEG;
            ST_INTEG:    n_state = ST_MUL_P;
            ST_MUL_P:    n_state = ST_ACC_P;
            ST_ACC_P:    n_state = ST_ACC_I;
            ST_ACC_I:    n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: if (!i_stat.div_busy) n_state = ST_MUL_D;
            ST_MUL_D:    n_state = ST_ACC_D;
            ST_ACC_D:    n_state = ST_FINISH;
            ST_FINISH:   if (i_stat.out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_DT;
        o_cmd.acc_op  = ACC_HOLD;
        o_in_stall    = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_ERR: begin
                o_cmd.calc_err = 1'b1;
            end
            ST_MUL_DT: begin
                o_cmd.mul_go    = 1'b1;
                o_cmd.mul_sel   = MUL_DT;
                o_cmd.div_start = 1'b1;
            end
            ST_INTEG: begin
                o_cmd.integ_upd = 1'b1;
            end
            ST_MUL_P: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MUL_P;
            end
            ST_ACC_P: begin
                o_cmd.acc_op  = ACC_LOAD;
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MUL_I;
            end
            ST_ACC_I: begin
                o_cmd.acc_op = ACC_ADD;
            end
            ST_DIV_WAIT: begin
                o_cmd.acc_op = ACC_HOLD;
            end
            ST_MUL_D: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MUL_D;
            end
            ST_ACC_D: begin
                o_cmd.acc_op = ACC_ADD;
            end
            ST_FINISH: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/pid_speed_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID speed controller
// Each input word carries a target speed, a measured speed and a time step;
// each produces one clamped acceleration command word.
//
// The input channel takes a word when i_in_valid is high and o_in_stall is
// low. The output channel offers a word on o_out_valid and it is taken when
// i_out_stall is low. Gains and bounds are to be written through the indexed
// write port only while no word is in flight; the block itself does not
// enforce this. Writes to unused indexes are ignored. A word is accepted only
// while the sequencer is idle. Its result is offered on o_out_valid after the
// serial divider forming the derivative, which resolves one quotient bit per
// cycle over 33 bits, has finished; the next word is taken only after that
// result is loaded into the output register.
// The result waits in an output register, so a stalled receiver does not
// hold up the next input word until its result is ready too.
// Reset restores the default gains and bounds, clears the integral and the
// previous error, and leaves both channels empty.
// ----------------------------------------------------------------------------
module pid_speed_controller import psc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SPEED_WIDTH-1:0] i_target_speed,
    input  logic [SPEED_WIDTH-1:0] i_measured_speed,
    input  logic [DT_W-1:0]        i_time_step,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [CMD_W-1:0]       o_accel_command,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wr_data
);

    t_cfg     w_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    psc_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_wr_en),
        .i_index   (i_cfg_index),
        .i_wr_data (i_cfg_wr_data),
        .o_cfg     (w_cfg)
    );

    psc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    psc_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg            (w_cfg),
        .i_target_speed   (i_target_speed),
        .i_measured_speed (i_measured_speed),
        .i_time_step      (i_time_step),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_accel_command  (o_accel_command)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Sequencer did not leave idle after accepting a word.");

    a_cmd_within_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ($signed(o_accel_command) <= $signed({1'b0, w_cfg.accel_bound})) &&
            ($signed(o_accel_command) >= -$signed({1'b0, w_cfg.accel_bound})))
        else $error("Acceleration command exceeds its bound.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_in_stall && !o_out_valid))
        else $error("Channels not empty after reset.");

endmodule
